[rtl/csb_pkg.sv]
// Shared types and constants for the cross stencil blur stream unit.
`default_nettype none

package csb_pkg;

    // Line buffer geometry.
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int VALUE_W    = 12;
    localparam int SUM_W      = PIX_W + 3;
    localparam int W_CFG_W    = 11;
    localparam int H_CFG_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    // Effective width needs room for both the register value and MAX_WIDTH itself.
    localparam int WEFF_W = (ADDR_W + 1 > W_CFG_W) ? ADDR_W + 1 : W_CFG_W;

    // Configuration reset values.
    localparam int WIDTH_RESET  = 4;
    localparam int HEIGHT_RESET = 4;

    // Largest result value: ten times the largest gray level.
    localparam int VALUE_MAX = 2550;

    // Request kinds carried on s_tuser.
    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // One line buffer word: the row above and the center row for one column.
    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] center;
    } line_word_t;

    // One result item.
    typedef struct packed {
        logic               last;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

`default_nettype wire

[rtl/csb_line_ram.sv]
// Line buffer memory: one write port, two registered read ports with write-through.
`default_nettype none

module csb_line_ram (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [csb_pkg::ADDR_W-1:0] wr_addr,
    input  wire csb_pkg::line_word_t       wr_data,
    input  wire logic [csb_pkg::ADDR_W-1:0] rd_addr_a,
    input  wire logic [csb_pkg::ADDR_W-1:0] rd_addr_b,
    output csb_pkg::line_word_t            rd_data_a,
    output csb_pkg::line_word_t            rd_data_b
);

    csb_pkg::line_word_t mem [0:csb_pkg::MAX_WIDTH-1];
    csb_pkg::line_word_t rd_a_reg;
    csb_pkg::line_word_t rd_b_reg;

    // Write, then read; a read of the address being written returns the new word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_a_reg <= wr_data;
        end else begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_reg <= wr_data;
        end else begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

[rtl/csb_core.sv]
// Raster counters, configuration registers, line buffers and the stencil arithmetic.
`default_nettype none

module csb_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration writes.
    input  wire logic                          cfg_valid,
    input  wire logic [csb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0] cfg_data,
    // Accepted request.
    input  wire logic                          in_accept,
    input  wire csb_pkg::op_t                  in_op,
    input  wire logic [csb_pkg::PIX_W-1:0]      in_pixel,
    output logic                               core_ready,
    // Result of the accepted request.
    output logic                               res_valid,
    output csb_pkg::result_t                   res
);

    logic [csb_pkg::ADDR_W-1:0]  col_reg, col_next;
    logic [csb_pkg::H_CFG_W-1:0] row_reg, row_next;
    logic [csb_pkg::PIX_W-1:0]   left_reg, left_next;
    logic                        drain_reg, drain_next;
    logic                        run_reg;
    logic [csb_pkg::W_CFG_W-1:0] width_reg;
    logic [csb_pkg::H_CFG_W-1:0] height_reg;

    logic [csb_pkg::WEFF_W-1:0]  width_ext;
    logic [csb_pkg::WEFF_W-1:0]  w_eff;
    logic [csb_pkg::WEFF_W-1:0]  w_last;
    logic [csb_pkg::H_CFG_W-1:0] h_last;
    logic                        col_end;
    logic                        row_end;
    logic                        border;

    logic                        wr_en;
    csb_pkg::line_word_t         wr_data;
    logic [csb_pkg::ADDR_W-1:0]  rd_addr_a;
    logic [csb_pkg::ADDR_W-1:0]  rd_addr_b;
    csb_pkg::line_word_t         win_a;
    csb_pkg::line_word_t         win_b;

    logic [csb_pkg::SUM_W-1:0]   sum;
    logic [csb_pkg::VALUE_W-1:0] ten_center;
    logic [csb_pkg::VALUE_W-1:0] twice_sum;

    // Line buffers: word[c] holds the row above and the center row of column c.
    csb_line_ram u_line_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (col_reg),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (win_a),
        .rd_data_b (win_b)
    );

    // The memory reads the column the counter holds after this edge, so the
    // window is current at every cycle whether or not a request is taken.
    assign rd_addr_a = aresetn ? col_next : '0;
    assign rd_addr_b = rd_addr_a + 1'b1;

    // Effective frame size.
    always_comb begin
        width_ext = csb_pkg::WEFF_W'(width_reg);
        if (width_reg == '0) begin
            w_eff = csb_pkg::WEFF_W'(1);
        end else if (width_ext > csb_pkg::WEFF_W'(csb_pkg::MAX_WIDTH)) begin
            w_eff = csb_pkg::WEFF_W'(csb_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_ext;
        end
        w_last = w_eff - 1'b1;
        h_last = (height_reg == '0) ? '0 : height_reg - 1'b1;
    end

    assign col_end = (csb_pkg::WEFF_W'(col_reg) >= w_last);
    assign row_end = (row_reg >= h_last);

    // The output row is one behind the input row; its edges pass through.
    assign border = (row_reg == csb_pkg::H_CFG_W'(1)) || ((row_reg - 1'b1) >= h_last) ||
                    (col_reg == '0) || col_end;

    // Five-point sum and the two result forms, both in tenths.
    assign sum = csb_pkg::SUM_W'(win_a.above) + csb_pkg::SUM_W'(left_reg) +
                 csb_pkg::SUM_W'(win_a.center) + csb_pkg::SUM_W'(win_b.center) +
                 csb_pkg::SUM_W'(in_pixel);
    assign twice_sum  = csb_pkg::VALUE_W'({sum, 1'b0});
    assign ten_center = (csb_pkg::VALUE_W'(win_a.center) << 3) +
                        (csb_pkg::VALUE_W'(win_a.center) << 1);

    assign wr_data.above  = win_a.center;
    assign wr_data.center = in_pixel;

    // Request handling and counter advance.
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        drain_next = drain_reg;
        wr_en      = 1'b0;
        res_valid  = 1'b0;
        res.value  = ten_center;
        res.last   = 1'b0;
        if (in_accept) begin
            case (in_op)
                csb_pkg::OP_PIXEL: begin
                    if (!drain_reg) begin
                        wr_en     = 1'b1;
                        left_next = win_a.center;
                        res_valid = (row_reg != '0);
                        res.value = border ? ten_center : twice_sum;
                        if (col_end) begin
                            col_next = '0;
                            if (row_end) begin
                                row_next   = '0;
                                drain_next = 1'b1;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
                csb_pkg::OP_DRAIN: begin
                    if (drain_reg) begin
                        res_valid = 1'b1;
                        res.last  = col_end;
                        if (col_end) begin
                            col_next   = '0;
                            drain_next = 1'b0;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Control state; the first cycle after reset primes the line buffer reads.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            drain_reg <= 1'b0;
            run_reg   <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
            drain_reg <= drain_next;
            run_reg   <= 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= csb_pkg::W_CFG_W'(csb_pkg::WIDTH_RESET);
            height_reg <= csb_pkg::H_CFG_W'(csb_pkg::HEIGHT_RESET);
        end else if (cfg_valid) begin
            case (cfg_index)
                csb_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data[csb_pkg::W_CFG_W-1:0];
                end
                csb_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data[csb_pkg::H_CFG_W-1:0];
                end
                default: begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    assign core_ready = run_reg;

endmodule

`default_nettype wire

[rtl/csb_skid.sv]
// Output register with a skid stage so requests keep flowing while a result waits.
`default_nettype none

module csb_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire csb_pkg::result_t push_data,
    output logic                  push_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output csb_pkg::result_t      out_data
);

    logic             out_valid_reg, out_valid_next;
    csb_pkg::result_t out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    csb_pkg::result_t skid_data_reg, skid_data_next;

    // The output register refills from the skid stage first, else from the core.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

`default_nettype wire

[rtl/cross_stencil_blur_stream_unit.sv]
// Top level: five-point cross mean filter over a raster pixel stream.
// A result is registered in the output register, or in the skid stage while the output stalls.
// Throughput: one request per cycle while not stalled; line buffer reads repeat every cycle.
// s_tready drops while the skid stage holds a result that the sink has not taken.
// Reset (aresetn low, synchronous) clears counters, outputs and configuration to 4 x 4;
// line buffers are not cleared, and s_tready is held low until the run flag is registered.
`default_nettype none

module cross_stencil_blur_stream_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Pixel request channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [csb_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] pixel
    input  wire logic                           s_tuser,   // [0] operation
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [csb_pkg::M_TDATA_W-1:0]        m_tdata,   // [11:0] value_tenths, rest zero
    output logic                                m_tlast    // frame_last
);

    logic             core_ready;
    logic             skid_ready;
    logic             in_accept;
    logic             res_valid;
    csb_pkg::result_t res;
    csb_pkg::result_t out_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = core_ready && skid_ready;
    assign in_accept = s_tvalid && s_tready;

    csb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .in_op      (csb_pkg::op_t'(s_tuser)),
        .in_pixel   (s_tdata[csb_pkg::PIX_W-1:0]),
        .core_ready (core_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    csb_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (skid_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    // Result payload, zero-padded to whole bytes.
    assign m_tdata = csb_pkg::M_TDATA_W'(out_data.value);
    assign m_tlast = out_data.last;

endmodule

`default_nettype wire

[rtl/csb_checker.sv]
// Port-level checks for the cross stencil blur stream unit, bound to the top level.
`default_nettype none

module csb_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [csb_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // A value in tenths never exceeds ten times the brightest gray level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= csb_pkg::M_TDATA_W'(csb_pkg::VALUE_MAX)))
        else $error("result value out of range");

    // Reset empties the output stage.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind cross_stencil_blur_stream_unit csb_checker u_csb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[verif/cross_stencil_blur_stream_unit_test.sv]
// Self-checking testbench for the five-point cross blur stream unit.
module cross_stencil_blur_stream_unit_test;
    import csb_pkg::*;

    // Cycles with no accepted request on any channel before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;

    // Frame sizes written in the first phases; later phases pick small random sizes.
    localparam int FIXED_WIDTHS  [8] = '{0, 1, 11, 3, 7, 2, 5, 1};
    localparam int FIXED_HEIGHTS [8] = '{0, 9, 3, 0, 1, 3, 4, 2};
    localparam int PHASE_COUNT       = 16;
    localparam int PHASE_ITEMS       = 50;

    // Idling modes: none, sender only, receiver only, both.
    localparam int GAP_PCT   [4] = '{0, 45, 0, 30};
    localparam int STALL_PCT [4] = '{0, 0, 45, 30};

    typedef enum bit {
        ROW_LITERAL,
        ROW_PREDICTED
    } row_check_t;

    typedef struct packed {
        op_t                op;
        logic [PIX_W-1:0]   px;
        row_check_t         check;
        bit                 has_result;
        logic [VALUE_W-1:0] value;
        bit                 last;
    } probe_row_t;

    // One 4 x 4 frame at the reset size, with ignored requests around it.
    localparam probe_row_t FRAME_PROBE [23] = '{
        '{OP_DRAIN, 8'd0,   ROW_LITERAL,   1'b0, 12'd0,    1'b0},  // nothing pending
        '{OP_PIXEL, 8'd0,   ROW_LITERAL,   1'b0, 12'd0,    1'b0},  // row 0
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b0, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b0, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd0,   ROW_LITERAL,   1'b0, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b1, 12'd0,    1'b0},  // row 1: top border out
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b1, 12'd2550, 1'b0},
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b1, 12'd2550, 1'b0},
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b1, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd0,   ROW_LITERAL,   1'b1, 12'd2550, 1'b0},  // row 2
        '{OP_PIXEL, 8'd255, ROW_LITERAL,   1'b1, 12'd2550, 1'b0},  // all five at full scale
        '{OP_PIXEL, 8'd93,  ROW_PREDICTED, 1'b0, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd0,   ROW_LITERAL,   1'b1, 12'd2550, 1'b0},
        '{OP_PIXEL, 8'd17,  ROW_LITERAL,   1'b1, 12'd0,    1'b0},  // row 3
        '{OP_PIXEL, 8'd200, ROW_PREDICTED, 1'b0, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd1,   ROW_PREDICTED, 1'b0, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd128, ROW_LITERAL,   1'b1, 12'd0,    1'b0},
        '{OP_PIXEL, 8'd77,  ROW_LITERAL,   1'b0, 12'd0,    1'b0},  // pixel while draining
        '{OP_DRAIN, 8'd0,   ROW_LITERAL,   1'b1, 12'd170,  1'b0},  // bottom row
        '{OP_DRAIN, 8'd255, ROW_LITERAL,   1'b1, 12'd2000, 1'b0},
        '{OP_DRAIN, 8'd0,   ROW_LITERAL,   1'b1, 12'd10,   1'b0},
        '{OP_DRAIN, 8'd0,   ROW_LITERAL,   1'b1, 12'd1280, 1'b1},
        '{OP_DRAIN, 8'd0,   ROW_LITERAL,   1'b0, 12'd0,    1'b0}   // nothing pending
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [7:0] pixel
    logic                  s_tuser;   // [0] operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [11:0] value_tenths, rest zero
    logic                  m_tlast;

    // Predictor state: line buffers, neighbor, counters and frame size.
    bit [PIX_W-1:0]   above_line  [MAX_WIDTH];
    bit [PIX_W-1:0]   center_line [MAX_WIDTH];
    bit [PIX_W-1:0]   left_px;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    bit               drain_wait;
    logic [W_CFG_W-1:0] width_reg;
    logic [H_CFG_W-1:0] height_reg;

    result_t blurred_due [$];
    int      mismatch_count;
    int      quiet_cycles;
    int      send_gap_pct;
    int      sink_stall_pct;

    cross_stencil_blur_stream_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned fit_width(input int unsigned w);
        return (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    endfunction

    function automatic int unsigned fit_height(input int unsigned h);
        return (h == 0) ? 1 : h;
    endfunction

    function automatic int unsigned center_at(input int unsigned idx);
        return (idx < MAX_WIDTH) ? center_line[idx] : 0;
    endfunction

    // Advances the predictor by one request and returns the blurred pixel it causes.
    function automatic void blur_predict(input op_t op, input logic [PIX_W-1:0] px,
                                         output bit has_result, output result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned center;
        int unsigned above;
        int unsigned v;
        bit          border;
        w = fit_width(width_reg);
        h = fit_height(height_reg);
        c = col_cnt;
        r = row_cnt;
        has_result = 1'b0;
        res = '0;
        if (op == OP_DRAIN) begin
            // Each drain taken while the bottom row waits emits one bottom-row pixel, always a border pixel.
            if (drain_wait) begin
                has_result = 1'b1;
                res.value = VALUE_W'(10 * center_at(c));
                res.last = (c >= w - 1);
                if (res.last) begin
                    col_cnt = 0;
                    drain_wait = 1'b0;
                end else begin
                    col_cnt = c + 1;
                end
            end
        end else if (!drain_wait) begin
            center = center_at(c);
            above = (c < MAX_WIDTH) ? above_line[c] : 0;
            // The row above the incoming one is emitted one row late.
            if (r >= 1) begin
                border = (r - 1 == 0) || (r - 1 >= h - 1) || (c == 0) || (c >= w - 1);
                if (border) begin
                    v = 10 * center;
                end else begin
                    v = 2 * (above + left_px + center + center_at(c + 1) + px);
                end
                has_result = 1'b1;
                res.value = VALUE_W'(v);
            end
            if (c < MAX_WIDTH) begin
                above_line[c] = PIX_W'(center);
                center_line[c] = px;
            end
            left_px = PIX_W'(center);
            // Row and frame wrap; the frame end leaves the bottom row to drain.
            if (c >= w - 1) begin
                col_cnt = 0;
                if (r >= h - 1) begin
                    row_cnt = 0;
                    drain_wait = 1'b1;
                end else begin
                    row_cnt = r + 1;
                end
            end else begin
                col_cnt = c + 1;
            end
        end
    endfunction

    function automatic logic [PIX_W-1:0] draw_gray();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Offers one request after a random gap and records what it should produce.
    task automatic send_request(input op_t op, input logic [PIX_W-1:0] px,
                                input bit from_table, input bit table_has,
                                input result_t table_res);
        bit      has_result;
        result_t res;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        blur_predict(op, px, has_result, res);
        if (from_table) begin
            has_result = table_has;
            res = table_res;
        end
        if (has_result) begin
            blurred_due.push_back(res);
        end
        @(negedge aclk);
    endtask

    // Holds the sender off until every blurred pixel owed has come out.
    task automatic pause_for_results(input int extra);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (blurred_due.size() != 0);
        repeat (extra) @(negedge aclk);
    endtask

    // Writes both size registers, width first.
    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        cfg_index_t idx;
        for (int i = 0; i < 2; i++) begin
            idx = cfg_index_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= (idx == CFG_IMAGE_WIDTH) ? CFG_DATA_W'(w) : CFG_DATA_W'(h);
            do @(posedge aclk); while (!cfg_ready);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = W_CFG_W'(w);
            end else begin
                height_reg = H_CFG_W'(h);
            end
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // One frame of random gray levels and its drain, with stray requests mixed in.
    task automatic run_frame(input int unsigned w, input int unsigned h);
        int unsigned n;
        for (n = 0; n < w * h; n++) begin
            if ($urandom_range(24) == 0) begin
                send_request(OP_DRAIN, PIX_W'($urandom), 1'b0, 1'b0, '0);
            end
            if ($urandom_range(79) == 0) begin
                pause_for_results(0);
            end
            send_request(OP_PIXEL, draw_gray(), 1'b0, 1'b0, '0);
        end
        for (n = 0; n < w; n++) begin
            if ($urandom_range(14) == 0) begin
                send_request(OP_PIXEL, draw_gray(), 1'b0, 1'b0, '0);
            end
            send_request(OP_DRAIN, PIX_W'($urandom), 1'b0, 1'b0, '0);
        end
    endtask

    // Receiver side: random backpressure, changed at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compares each accepted result with the oldest blurred pixel owed.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (blurred_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual tdata %0d last %0b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = blurred_due.pop_front();
                if (m_tdata !== M_TDATA_W'(want.value) || m_tlast !== want.last) begin
                    mismatch_count++;
                    $display("%0t: result mismatch: expected tdata %0d last %0b, %s %0d %s %0b",
                             $time, want.value, want.last, "actual tdata", m_tdata,
                             "last", m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles in which no request moves on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("cross_stencil_blur_stream_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        result_t     row_res;
        int          phase;
        int unsigned w_set;
        int unsigned h_set;
        int unsigned done;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = OP_PIXEL;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        sink_stall_pct = 0;
        left_px = '0;
        col_cnt = 0;
        row_cnt = 0;
        drain_wait = 1'b0;
        width_reg = W_CFG_W'(WIDTH_RESET);
        height_reg = H_CFG_W'(HEIGHT_RESET);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frame at the reset size.
        foreach (FRAME_PROBE[i]) begin
            row_res.value = FRAME_PROBE[i].value;
            row_res.last = FRAME_PROBE[i].last;
            send_request(FRAME_PROBE[i].op, FRAME_PROBE[i].px,
                         FRAME_PROBE[i].check == ROW_LITERAL,
                         FRAME_PROBE[i].has_result, row_res);
        end

        // Tallest frame cut short: the height drops under the row counter mid-frame.
        pause_for_results(2);
        set_frame_size(1, 8191);
        repeat (20) send_request(OP_PIXEL, draw_gray(), 1'b0, 1'b0, '0);
        pause_for_results(2);
        set_frame_size(1, 1);
        send_request(OP_PIXEL, draw_gray(), 1'b0, 1'b0, '0);
        send_request(OP_DRAIN, draw_gray(), 1'b0, 1'b0, '0);

        // Random frames over a range of sizes and idling modes.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase < 8) begin
                w_set = FIXED_WIDTHS[phase];
                h_set = FIXED_HEIGHTS[phase];
            end else begin
                w_set = $urandom_range(12, 1);
                h_set = $urandom_range(6, 1);
            end
            pause_for_results(2);
            send_gap_pct = GAP_PCT[phase % 4];
            sink_stall_pct = STALL_PCT[phase % 4];
            set_frame_size(w_set, h_set);
            done = 0;
            while (done < PHASE_ITEMS) begin
                run_frame(fit_width(w_set), fit_height(h_set));
                done += fit_width(w_set) * (fit_height(h_set) + 1);
            end
        end

        pause_for_results(10);
        if (mismatch_count == 0) begin
            $display("cross_stencil_blur_stream_unit: match");
        end else begin
            $display("cross_stencil_blur_stream_unit: mismatch");
        end
        $finish;
    end

endmodule
